// ===== design/ffba_pkg.sv =====
// Shared constants of the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int DEF_BUFFER_BYTES = 65536;
  localparam int DEF_MAX_BLOCKS   = 256;
  localparam int DEF_HEADER_BYTES = 16;

  localparam int ALIGN_W  = 3;
  localparam int BUFCFG_W = 17;
  localparam int ALLOC_W  = 17;
  localparam int BOFF_W   = 16;
  localparam int DOFF_W   = 16;
  localparam int STAT_W   = 2;
  localparam int NEED_W   = 18;
  localparam int CIDX_W   = 1;

  localparam logic [ALIGN_W-1:0]  ALIGN_RESET  = 3'd3;
  localparam logic [BUFCFG_W-1:0] BUFCFG_RESET = 17'd65536;

  localparam logic [CIDX_W-1:0] CFG_ALIGN = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_BUF   = 1'd1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FIT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_OFF = 2'd2;

endpackage

// ===== design/ffba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/ffba_geom.sv =====
// Alignment rounding of header and request sizes and the initial free block size.
`timescale 1ns / 1ps
module ffba_geom
  import ffba_pkg::*;
#(
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int OFF_W        = 17,
  parameter int AW           = 20
) (
  input  logic [ALIGN_W-1:0]  align_log2_i,
  input  logic [BUFCFG_W-1:0] buffer_bytes_i,
  input  logic [ALLOC_W-1:0]  alloc_bytes_i,
  output logic [AW-1:0]       hdr_o,
  output logic [AW-1:0]       need_o,
  output logic [OFF_W-1:0]    init_size_o
);

  logic [AW-1:0] amask;
  logic [AW-1:0] buf_x;
  logic [AW-1:0] buf_lim;

  always_comb begin
    amask   = ~({AW{1'b1}} << align_log2_i);
    hdr_o   = (AW'(HEADER_BYTES) + amask) & ~amask;
    need_o  = (AW'(alloc_bytes_i) + amask) & ~amask;
    buf_x   = AW'(buffer_bytes_i);
    buf_lim = (buf_x > AW'(BUFFER_BYTES)) ? AW'(BUFFER_BYTES) : buf_x;
    init_size_o = (buf_lim > hdr_o) ? OFF_W'(buf_lim - hdr_o) : '0;
  end

endmodule

// ===== design/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator with coalescing of free neighbors.
`timescale 1ns / 1ps
// The allocator keeps the managed buffer as an address-ordered table of blocks in a
// single RAM, one entry per block holding its header offset, data size and free flag.
// One item is handled at a time. An allocate item walks the table from the start,
// reading and then checking each entry, until the first free block large enough
// for the aligned size; when the remainder can hold another header and the table has
// room, every later entry moves up one slot before the new free block is written.
// A free item walks the table the same way to find the matching data offset; unless
// that block is already free, it looks at both neighbors, writes the merged block and
// moves the later entries down over any absorbed neighbors. After reset and after
// every configuration write the table is rebuilt as one free block, and no item is
// taken while this happens. Configuration is accepted only between items, and an
// offered configuration write takes precedence over an offered item. A finished
// result sits in an output register, so the next item may be taken while it waits.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [ALLOC_W-1:0]  alloc_bytes_i,
  input  logic [BOFF_W-1:0]   block_offset_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DOFF_W-1:0]   data_offset_o,
  output logic [STAT_W-1:0]   status_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CIDX_W-1:0]   cfg_index_i,
  input  logic [BUFCFG_W-1:0] cfg_data_i
);

  localparam int OFF_W = $clog2(BUFFER_BYTES + 1);
  localparam int AW    = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 2;
  localparam int E_W   = 2 * OFF_W + 1;
  localparam int IW    = $clog2(MAX_BLOCKS);
  localparam int CW    = $clog2(MAX_BLOCKS + 1);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_CHK = 4'd3;
  localparam logic [3:0] S_A_NEW = 4'd4;
  localparam logic [3:0] S_A_CUR = 4'd5;
  localparam logic [3:0] S_F_RD  = 4'd6;
  localparam logic [3:0] S_F_CHK = 4'd7;
  localparam logic [3:0] S_F_RN  = 4'd8;
  localparam logic [3:0] S_F_NX  = 4'd9;
  localparam logic [3:0] S_F_RP  = 4'd10;
  localparam logic [3:0] S_F_PX  = 4'd11;
  localparam logic [3:0] S_F_WR  = 4'd12;
  localparam logic [3:0] S_CP_RD = 4'd13;
  localparam logic [3:0] S_CP_WR = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0]          state_q, state_d;
  logic [ALIGN_W-1:0]  align_q, align_d;
  logic [BUFCFG_W-1:0] bufcfg_q, bufcfg_d;
  logic [ALLOC_W-1:0]  alloc_q, alloc_d;
  logic [BOFF_W-1:0]   target_q, target_d;
  logic [CW-1:0]       i_q, i_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       r_q, r_d;
  logic [CW-1:0]       w_q, w_d;
  logic [CW-1:0]       n_q, n_d;
  logic                cp_up_q, cp_up_d;
  logic                split_q, split_d;
  logic                nf_q, nf_d;
  logic                pf_q, pf_d;
  logic [OFF_W-1:0]    cur_off_q, cur_off_d;
  logic [AW-1:0]       cur_size_q, cur_size_d;
  logic [DOFF_W-1:0]   res_dof_q, res_dof_d;
  logic [STAT_W-1:0]   res_st_q, res_st_d;
  logic                out_valid_q, out_valid_d;
  logic [DOFF_W-1:0]   out_dof_q, out_dof_d;
  logic [STAT_W-1:0]   out_st_q, out_st_d;

  logic [AW-1:0]    hdr;
  logic [AW-1:0]    need;
  logic [OFF_W-1:0] init_size;

  logic          we;
  logic [IW-1:0] waddr;
  logic [E_W-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [E_W-1:0] rdata;

  logic [OFF_W-1:0] e_off;
  logic [AW-1:0]    e_size;
  logic             e_free;
  logic [AW-1:0]    e_data_off;
  logic [CW-1:0]    i_inc;
  logic [CW-1:0]    src;
  logic [CW-1:0]    dst;
  logic [CW-1:0]    removed;

  ffba_geom #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .OFF_W        (OFF_W),
    .AW           (AW)
  ) u_geom (
    .align_log2_i   (align_q),
    .buffer_bytes_i (bufcfg_q),
    .alloc_bytes_i  (alloc_q),
    .hdr_o          (hdr),
    .need_o         (need),
    .init_size_o    (init_size)
  );

  ffba_ram #(
    .WIDTH (E_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Fields of the entry read in the previous cycle.
  assign e_off      = rdata[OFF_W-1:0];
  assign e_size     = AW'(rdata[2*OFF_W-1:OFF_W]);
  assign e_free     = rdata[E_W-1];
  assign e_data_off = AW'(e_off) + hdr;
  assign i_inc      = i_q + CW'(1);
  assign src        = i_inc + CW'(nf_q);
  assign dst        = pf_q ? (i_q - CW'(1)) : i_q;
  assign removed    = CW'(nf_q) + CW'(pf_q);

  // A pending configuration write holds off the input so that no item is dropped.
  assign in_stall_o    = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign data_offset_o = out_dof_q;
  assign status_o      = out_st_q;

  always_comb begin
    state_d    = state_q;
    align_d    = align_q;
    bufcfg_d   = bufcfg_q;
    alloc_d    = alloc_q;
    target_d   = target_q;
    i_d        = i_q;
    cnt_d      = cnt_q;
    r_d        = r_q;
    w_d        = w_q;
    n_d        = n_q;
    cp_up_d    = cp_up_q;
    split_d    = split_q;
    nf_d       = nf_q;
    pf_d       = pf_q;
    cur_off_d  = cur_off_q;
    cur_size_d = cur_size_q;
    res_dof_d  = res_dof_q;
    res_st_d   = res_st_q;
    out_dof_d  = out_dof_q;
    out_st_d   = out_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    we    = 1'b0;
    waddr = i_q[IW-1:0];
    wdata = '0;
    raddr = i_q[IW-1:0];

    unique case (state_q)
      S_INIT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = {1'b1, init_size, {OFF_W{1'b0}}};
        cnt_d   = CW'(1);
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid_i) begin
          case (cfg_index_i)
            CFG_ALIGN: align_d  = cfg_data_i[ALIGN_W-1:0];
            CFG_BUF:   bufcfg_d = cfg_data_i;
            default:   bufcfg_d = bufcfg_q;
          endcase
          state_d = S_INIT;
        end else if (in_valid_i) begin
          alloc_d  = alloc_bytes_i;
          target_d = block_offset_i;
          i_d      = '0;
          state_d  = (req_type_i == REQ_FREE) ? S_F_RD : S_A_RD;
        end
      end
      S_A_RD: begin
        if (i_q == cnt_q) begin
          res_dof_d = '0;
          res_st_d  = STAT_NO_FIT;
          state_d   = S_DONE;
        end else begin
          state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (e_free && (e_size >= need)) begin
          cur_off_d  = e_off;
          cur_size_d = e_size;
          if ((e_size >= need + hdr) && (cnt_q < CW'(MAX_BLOCKS))) begin
            // Open a slot after this block for the split-off remainder.
            split_d = 1'b1;
            cp_up_d = 1'b1;
            r_d     = cnt_q - CW'(1);
            w_d     = cnt_q;
            n_d     = cnt_q - i_inc;
            state_d = S_CP_RD;
          end else begin
            split_d = 1'b0;
            state_d = S_A_CUR;
          end
        end else begin
          i_d     = i_inc;
          state_d = S_A_RD;
        end
      end
      S_A_NEW: begin
        we      = 1'b1;
        waddr   = i_inc[IW-1:0];
        wdata   = {1'b1, OFF_W'(cur_size_q - hdr - need),
                   OFF_W'(AW'(cur_off_q) + hdr + need)};
        state_d = S_A_CUR;
      end
      S_A_CUR: begin
        we    = 1'b1;
        waddr = i_q[IW-1:0];
        wdata = {1'b0, OFF_W'(split_q ? need : cur_size_q), cur_off_q};
        if (split_q) begin
          cnt_d = cnt_q + CW'(1);
        end
        res_dof_d = DOFF_W'(AW'(cur_off_q) + hdr);
        res_st_d  = STAT_OK;
        state_d   = S_DONE;
      end
      S_F_RD: begin
        if (i_q == cnt_q) begin
          res_dof_d = '0;
          res_st_d  = STAT_BAD_OFF;
          state_d   = S_DONE;
        end else begin
          state_d = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if ((e_data_off[DOFF_W-1:0] == target_q) && (e_data_off <= AW'(16'hFFFF))) begin
          res_dof_d = '0;
          res_st_d  = STAT_OK;
          if (e_free) begin
            state_d = S_DONE;
          end else begin
            cur_off_d  = e_off;
            cur_size_d = e_size;
            nf_d       = 1'b0;
            pf_d       = 1'b0;
            state_d    = S_F_RN;
          end
        end else begin
          i_d     = i_inc;
          state_d = S_F_RD;
        end
      end
      S_F_RN: begin
        raddr   = i_inc[IW-1:0];
        state_d = (i_inc < cnt_q) ? S_F_NX : S_F_RP;
      end
      S_F_NX: begin
        if (e_free) begin
          nf_d       = 1'b1;
          cur_size_d = cur_size_q + hdr + e_size;
        end
        state_d = S_F_RP;
      end
      S_F_RP: begin
        raddr   = IW'(i_q - CW'(1));
        state_d = (i_q != '0) ? S_F_PX : S_F_WR;
      end
      S_F_PX: begin
        if (e_free) begin
          pf_d       = 1'b1;
          cur_off_d  = e_off;
          cur_size_d = cur_size_q + hdr + e_size;
        end
        state_d = S_F_WR;
      end
      S_F_WR: begin
        // Write the merged block, then close the gap left by absorbed entries.
        we      = 1'b1;
        waddr   = dst[IW-1:0];
        wdata   = {1'b1, OFF_W'(cur_size_q), cur_off_q};
        cp_up_d = 1'b0;
        r_d     = src;
        w_d     = dst + CW'(1);
        n_d     = (removed == '0) ? '0 : (cnt_q - src);
        cnt_d   = cnt_q - removed;
        state_d = S_CP_RD;
      end
      S_CP_RD: begin
        raddr = r_q[IW-1:0];
        if (n_q == '0) begin
          state_d = cp_up_q ? S_A_NEW : S_DONE;
        end else begin
          state_d = S_CP_WR;
        end
      end
      S_CP_WR: begin
        we    = 1'b1;
        waddr = w_q[IW-1:0];
        wdata = rdata;
        n_d   = n_q - CW'(1);
        if (cp_up_q) begin
          r_d = r_q - CW'(1);
          w_d = w_q - CW'(1);
        end else begin
          r_d = r_q + CW'(1);
          w_d = w_q + CW'(1);
        end
        state_d = S_CP_RD;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_dof_d   = res_dof_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      align_q     <= ALIGN_RESET;
      bufcfg_q    <= BUFCFG_RESET;
      cnt_q       <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      align_q     <= align_d;
      bufcfg_q    <= bufcfg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alloc_q    <= alloc_d;
    target_q   <= target_d;
    i_q        <= i_d;
    r_q        <= r_d;
    w_q        <= w_d;
    n_q        <= n_d;
    cp_up_q    <= cp_up_d;
    split_q    <= split_d;
    nf_q       <= nf_d;
    pf_q       <= pf_d;
    cur_off_q  <= cur_off_d;
    cur_size_q <= cur_size_d;
    res_dof_q  <= res_dof_d;
    res_st_q   <= res_st_d;
    out_dof_q  <= out_dof_d;
    out_st_q   <= out_st_d;
  end

endmodule
